@@ rtl/core/rieu_pkg.sv @@
package rieu_pkg;

	localparam logic [31:0] START_ADDR_RESET = 32'd256;

	localparam logic [5:0] OPC_J     = 6'b010000;
	localparam logic [5:0] OPC_JR    = 6'b010001;
	localparam logic [5:0] OPC_BEQ   = 6'b010010;
	localparam logic [5:0] OPC_BLTZ  = 6'b010011;
	localparam logic [5:0] OPC_BGTZ  = 6'b010100;
	localparam logic [5:0] OPC_BREAK = 6'b010101;
	localparam logic [5:0] OPC_SW    = 6'b010110;
	localparam logic [5:0] OPC_LW    = 6'b010111;
	localparam logic [5:0] OPC_SLL   = 6'b011000;
	localparam logic [5:0] OPC_SRL   = 6'b011001;
	localparam logic [5:0] OPC_SRA   = 6'b011010;
	localparam logic [5:0] OPC_NOP   = 6'b011011;
	localparam logic [5:0] OPC_ADD   = 6'b110000;
	localparam logic [5:0] OPC_SUB   = 6'b110001;
	localparam logic [5:0] OPC_MUL   = 6'b110010;
	localparam logic [5:0] OPC_AND   = 6'b110011;
	localparam logic [5:0] OPC_OR    = 6'b110100;
	localparam logic [5:0] OPC_XOR   = 6'b110101;
	localparam logic [5:0] OPC_NOR   = 6'b110110;
	localparam logic [5:0] OPC_SLT   = 6'b110111;
	localparam logic [5:0] OPC_ADDI  = 6'b111000;
	localparam logic [5:0] OPC_ANDI  = 6'b111001;
	localparam logic [5:0] OPC_ORI   = 6'b111010;
	localparam logic [5:0] OPC_XORI  = 6'b111011;

	// jump takes the top nibble of pc+4, ORed with word bit 25
	localparam int unsigned JUMP_REGION_LSB = 28;

	localparam logic [0:0] IN_OP_EXEC    = 1'b0;
	localparam logic [0:0] IN_OP_PRELOAD = 1'b1;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        taken;
		logic        reg_wr;
		logic        load;
		logic        store;
		logic [4:0]  dest;
		logic [31:0] value;
		logic [31:0] mem_addr;
		logic        set_halt;
		logic        unknown;
	} exec_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        reg_write;
		logic [4:0]  dest_reg;
		logic [31:0] dest_value;
		logic        store_done;
		logic [31:0] store_address;
		logic [31:0] store_value;
		logic        halted;
		logic        unknown_op;
	} result_t;

endpackage

@@ rtl/core/rieu_regfile.sv @@
module rieu_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rd_addr_a,
	input  logic [4:0]  rd_addr_b,
	input  logic        wr_en,
	input  logic [4:0]  wr_addr,
	input  logic [31:0] wr_data,
	output logic [31:0] rd_data_a,
	output logic [31:0] rd_data_b
);
	logic [31:0] mem [32];
	logic [31:0] vld_q;
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// write-first: a write on the read edge is returned directly
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr_a) begin
				rd_a_q <= wr_data;
			end else begin
				rd_a_q <= vld_q[rd_addr_a] ? mem[rd_addr_a] : 32'd0;
			end
			if (wr_en && wr_addr == rd_addr_b) begin
				rd_b_q <= wr_data;
			end else begin
				rd_b_q <= vld_q[rd_addr_b] ? mem[rd_addr_b] : 32'd0;
			end
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

@@ rtl/core/rieu_dmem.sv @@
module rieu_dmem #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [31:0]              wr_data,
	output logic [31:0]              rd_data,
	output logic                     busy
);
	localparam int unsigned AW = $clog2(DEPTH);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rd_q;
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;

	// zero sweep after reset, one word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= 32'd0;
		end else if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rd_data = rd_q;
	assign busy    = clr_q;

endmodule

@@ rtl/core/rieu_exec.sv @@
module rieu_exec (
	input  logic            [31:0] word,
	input  logic            [31:0] pc,
	input  logic            [31:0] a,
	input  logic            [31:0] b,
	output rieu_pkg::exec_t        res
);
	import rieu_pkg::*;

	logic [5:0]  opc;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [4:0]  sa;
	logic [31:0] imm;
	logic [31:0] seq;
	logic [31:0] br_target;
	logic [31:0] prod;

	assign opc       = word[31:26];
	assign rt        = word[20:16];
	assign rd        = word[15:11];
	assign sa        = word[10:6];
	assign imm       = {{16{word[15]}}, word[15:0]};
	assign seq       = pc + 32'd4;
	assign br_target = seq + {imm[29:0], 2'b00};
	assign prod      = a * b;

	always_comb begin
		res          = '0;
		res.next_pc  = seq;
		res.mem_addr = a + imm;
		unique case (opc)
			OPC_J: begin
				res.next_pc = {seq[31:JUMP_REGION_LSB] | {4{word[25]}}, word[25:0], 2'b00};
				res.taken   = 1'b1;
			end
			OPC_JR: begin
				res.next_pc = a;
				res.taken   = 1'b1;
			end
			OPC_BEQ: begin
				if (a == b) begin
					res.next_pc = br_target;
					res.taken   = 1'b1;
				end
			end
			OPC_BLTZ: begin
				if (a[31]) begin
					res.next_pc = br_target;
					res.taken   = 1'b1;
				end
			end
			OPC_BGTZ: begin
				if (!a[31] && a != 32'd0) begin
					res.next_pc = br_target;
					res.taken   = 1'b1;
				end
			end
			OPC_BREAK: begin
				res.next_pc  = pc;
				res.set_halt = 1'b1;
			end
			OPC_SW: res.store = 1'b1;
			OPC_LW: begin
				res.reg_wr = 1'b1;
				res.load   = 1'b1;
				res.dest   = rt;
			end
			OPC_SLL: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = b << sa;
			end
			OPC_SRL: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = b >> sa;
			end
			OPC_SRA: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = $unsigned($signed(b) >>> sa);
			end
			OPC_NOP: begin
			end
			OPC_ADD: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = a + b;
			end
			OPC_SUB: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = a - b;
			end
			OPC_MUL: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = prod;
			end
			OPC_AND: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = a & b;
			end
			OPC_OR: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = a | b;
			end
			OPC_XOR: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = a ^ b;
			end
			OPC_NOR: begin
				res.reg_wr = 1'b1; res.dest = rd; res.value = ~(a | b);
			end
			OPC_SLT: begin
				res.reg_wr = 1'b1; res.dest = rd;
				res.value  = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			end
			OPC_ADDI: begin
				res.reg_wr = 1'b1; res.dest = rt; res.value = a + imm;
			end
			OPC_ANDI: begin
				res.reg_wr = 1'b1; res.dest = rt; res.value = a & imm;
			end
			OPC_ORI: begin
				res.reg_wr = 1'b1; res.dest = rt; res.value = a | imm;
			end
			OPC_XORI: begin
				res.reg_wr = 1'b1; res.dest = rt; res.value = a ^ imm;
			end
			default: res.unknown = 1'b1;
		endcase
	end

endmodule

@@ rtl/core/risc_instruction_execute_unit.sv @@
// Pipeline: inputs register into stage 1, results into stage 2, then into the output register.
// Throughput: one item per cycle unless out_stall or the memory sweep holds; register file and data memory
// reads are synchronous, with forwarding from the write-back stage into execute.
// Reset: PC loads start_address, registers read as zero, halt clears. After reset
// the data memory is swept to zero, with input stalled.
// DATA_WORDS is a power of two; data addresses wrap on it.
module risc_instruction_execute_unit #(
	parameter int unsigned DATA_WORDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] word,
	input  logic [11:0] preload_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        branch_taken,
	output logic        reg_write,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value,
	output logic        store_done,
	output logic [31:0] store_address,
	output logic [31:0] store_value,
	output logic        halted,
	output logic        unknown_op
);
	import rieu_pkg::*;

	localparam int unsigned AW = $clog2(DATA_WORDS);

	logic [31:0] start_addr_q;
	logic        pc_init_q;
	logic [31:0] pc_q;
	logic        halt_q;

	logic        v_s1;
	logic        op_s1;
	logic [31:0] word_s1;
	logic [11:0] paddr_s1;

	logic        v_s2;
	logic        load_s2;
	result_t     res_s2;

	logic        out_v_q;
	result_t     out_q;

	logic        accept;
	logic        out_free;
	logic        adv_s2;
	logic        adv_s1;
	logic        exec_s1;
	logic        dm_busy;
	logic [31:0] dm_rdata;
	logic        dm_wr;
	logic        dm_rd;
	logic [AW-1:0] dm_addr;
	logic [31:0] dm_wdata;
	logic [31:0] rf_a;
	logic [31:0] rf_b;
	logic [31:0] wb_s2;
	logic [31:0] a_fwd;
	logic [31:0] b_fwd;
	logic [31:0] pre_byte;
	logic [AW-1:0] pre_idx;
	logic [AW-1:0] ex_idx;
	exec_t       ex;
	result_t     res_s1;
	result_t     res_wb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= START_ADDR_RESET;
		end else if (cfg_write) begin
			start_addr_q <= cfg_data;
		end
	end

	// handshake and stage advance
	assign out_free = !out_v_q || !out_stall;
	assign adv_s2   = v_s2 && out_free;
	assign adv_s1   = v_s1 && (!v_s2 || out_free);
	assign in_stall = dm_busy || (v_s1 && !adv_s1);
	assign accept   = in_valid && !in_stall;

	assign wb_s2 = load_s2 ? dm_rdata : res_s2.dest_value;
	assign a_fwd = (v_s2 && res_s2.reg_write && res_s2.dest_reg == word_s1[25:21]) ? wb_s2 : rf_a;
	assign b_fwd = (v_s2 && res_s2.reg_write && res_s2.dest_reg == word_s1[20:16]) ? wb_s2 : rf_b;

	rieu_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (word[25:21]),
		.rd_addr_b (word[20:16]),
		.wr_en     (adv_s2 && res_s2.reg_write),
		.wr_addr   (res_s2.dest_reg),
		.wr_data   (wb_s2),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b)
	);

	rieu_exec u_exec (
		.word (word_s1),
		.pc   (pc_q),
		.a    (a_fwd),
		.b    (b_fwd),
		.res  (ex)
	);

	assign exec_s1  = (op_s1 == IN_OP_EXEC) && !halt_q;
	assign pre_byte = {20'd0, paddr_s1};
	assign pre_idx  = pre_byte[AW+1:2];
	assign ex_idx   = ex.mem_addr[AW+1:2];

	assign dm_wr    = adv_s1 && ((op_s1 == IN_OP_PRELOAD) || (exec_s1 && ex.store));
	assign dm_rd    = adv_s1 && exec_s1 && ex.load;
	assign dm_addr  = (op_s1 == IN_OP_PRELOAD) ? pre_idx : ex_idx;
	assign dm_wdata = (op_s1 == IN_OP_PRELOAD) ? word_s1 : b_fwd;

	rieu_dmem #(
		.DEPTH (DATA_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (dm_wr),
		.rd_en   (dm_rd),
		.addr    (dm_addr),
		.wr_data (dm_wdata),
		.rd_data (dm_rdata),
		.busy    (dm_busy)
	);

	always_comb begin
		res_s1               = '0;
		res_s1.next_pc       = exec_s1 ? ex.next_pc : pc_q;
		res_s1.branch_taken  = exec_s1 && ex.taken;
		res_s1.reg_write     = exec_s1 && ex.reg_wr;
		res_s1.dest_reg      = exec_s1 ? ex.dest : 5'd0;
		res_s1.dest_value    = exec_s1 ? ex.value : 32'd0;
		res_s1.store_done    = exec_s1 && ex.store;
		res_s1.halted        = halt_q || (exec_s1 && ex.set_halt);
		res_s1.unknown_op    = exec_s1 && ex.unknown;
		if (exec_s1 && ex.store) begin
			res_s1.store_address = {{(30 - AW){1'b0}}, ex_idx, 2'b00};
			res_s1.store_value   = b_fwd;
		end
	end

	// loads take their value from the data memory read
	always_comb begin
		res_wb            = res_s2;
		res_wb.dest_value = wb_s2;
	end

	// pc loads the start address once out of reset, flagged by pc_init_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_init_q <= 1'b1;
			pc_q      <= START_ADDR_RESET;
			halt_q    <= 1'b0;
		end else if (pc_init_q) begin
			pc_init_q <= 1'b0;
			pc_q      <= start_addr_q;
		end else if (adv_s1 && exec_s1) begin
			pc_q <= ex.next_pc;
			if (ex.set_halt) begin
				halt_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
			if (adv_s2) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			word_s1  <= word;
			paddr_s1 <= preload_address;
		end
		if (adv_s1) begin
			res_s2  <= res_s1;
			load_s2 <= exec_s1 && ex.load;
		end
		if (adv_s2) begin
			out_q <= res_wb;
		end
	end

	assign out_valid     = out_v_q;
	assign next_pc       = out_q.next_pc;
	assign branch_taken  = out_q.branch_taken;
	assign reg_write     = out_q.reg_write;
	assign dest_reg      = out_q.dest_reg;
	assign dest_value    = out_q.dest_value;
	assign store_done    = out_q.store_done;
	assign store_address = out_q.store_address;
	assign store_value   = out_q.store_value;
	assign halted        = out_q.halted;
	assign unknown_op    = out_q.unknown_op;

endmodule
